@@ design/aavr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the axis-angle vector rotation block.
// No dependencies; every other design file imports this package.
package aavr_pkg;

   localparam int COMP_W        = 32;
   localparam int FRAC_BITS     = 16;
   localparam int NORM_W        = 30;
   localparam int REM_W         = 23;
   localparam int ANG_W         = COMP_W - FRAC_BITS + 1;
   localparam int BL_W          = 6;
   localparam int PROD_W        = 34;
   localparam int RECIP_SH      = 23;
   localparam int QUO_W         = PROD_W - RECIP_SH;
   localparam int CORDIC_STEPS  = 30;
   localparam int SQRT_STEPS    = 31;
   localparam int DIV_STEPS     = 31;

   localparam logic [ANG_W-1:0] ANG_BIAS   = 17'd33120;
   localparam logic [ANG_W-1:0] RECIP90    = 17'd93207;
   localparam logic [6:0]       DEG90      = 7'd90;
   localparam logic [24:0]      D2R30      = 25'd18740330;
   localparam logic [30:0]      CORDIC_K30 = 31'd652032874;

   localparam logic signed [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
   localparam logic signed [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

   localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
      30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
      30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
      30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
      30'd1023, 30'd511, 30'd255, 30'd127, 30'd63,
      30'd31, 30'd15, 30'd8, 30'd4, 30'd2
   };

   typedef logic signed [COMP_W-1:0] comp_type;

   typedef struct packed {
      comp_type vec_x;
      comp_type vec_y;
      comp_type vec_z;
      comp_type axis_x;
      comp_type axis_y;
      comp_type axis_z;
      comp_type angle_deg;
   } req_type;

   typedef struct packed {
      comp_type rot_x;
      comp_type rot_y;
      comp_type rot_z;
      logic     axis_zero;
      logic     overflow;
   } rsp_type;

   typedef struct packed {
      logic [2:0][COMP_W-1:0] vec;
      logic [2:0][NORM_W-1:0] mag;
      logic [2:0]             neg;
      logic                   zero;
      logic [1:0]             quad;
      logic [REM_W-1:0]       rem;
   } qent_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

@@ design/aavr_front.sv @@
`timescale 1ns / 1ps
// Front end: takes request beats, flags a zero axis, normalizes the axis
// magnitudes and splits the angle into quadrant and remainder. Uses aavr_pkg.
module aavr_front import aavr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   input  qstat_type qstat,
   output logic      push,
   output qent_type  push_ent
);

   logic [2:0]             vld_ff;
   logic                   adv;
   logic [2:0][COMP_W-1:0] vec_in, axis_in, mag_in;
   logic [2:0]             neg_in;
   logic [2:0][COMP_W-1:0] vec0_ff, vec1_ff, mag0_ff, mag1_ff;
   logic [2:0]             neg0_ff, neg1_ff;
   logic                   zero0_ff, zero1_ff;
   logic [ANG_W-1:0]       h_in, h0_ff, h1_ff;
   logic [FRAC_BITS-1:0]   alo0_ff, alo1_ff;
   logic [PROD_W-1:0]      prod1_ff;
   logic [COMP_W-1:0]      orm;
   logic [BL_W-1:0]        bl_in, bl1_ff;
   logic [QUO_W-1:0]       qd;
   logic [ANG_W-1:0]       qmul, remhi;
   logic [2:0][COMP_W-1:0] shl;
   qent_type               ent_in, ent_ff;

   assign adv       = !(vld_ff[2] && qstat.full);
   assign req_ready = adv;
   assign push      = vld_ff[2] && !qstat.full;
   assign push_ent  = ent_ff;

   assign vec_in  = {req_data.vec_z, req_data.vec_y, req_data.vec_x};
   assign axis_in = {req_data.axis_z, req_data.axis_y, req_data.axis_x};
   assign h_in    = {req_data.angle_deg[COMP_W-1], req_data.angle_deg[COMP_W-1:FRAC_BITS]}
                    + ANG_BIAS;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = axis_in[i][COMP_W-1];
         mag_in[i] = neg_in[i] ? (~axis_in[i] + 1'b1) : axis_in[i];
      end
   end

   always_comb begin
      orm   = mag0_ff[0] | mag0_ff[1] | mag0_ff[2];
      bl_in = '0;
      for (int i = 0; i < COMP_W; i++) begin
         if (orm[i]) begin
            bl_in = BL_W'(i + 1);
         end
      end
   end

   always_comb begin
      ent_in.vec  = vec1_ff;
      ent_in.neg  = neg1_ff;
      ent_in.zero = zero1_ff;
      for (int i = 0; i < 3; i++) begin
         if (bl1_ff > BL_W'(NORM_W)) begin
            shl[i] = mag1_ff[i] >> (bl1_ff - BL_W'(NORM_W));
         end else begin
            shl[i] = mag1_ff[i] << (BL_W'(NORM_W) - bl1_ff);
         end
         ent_in.mag[i] = shl[i][NORM_W-1:0];
      end
      qd          = prod1_ff[PROD_W-1:RECIP_SH];
      qmul        = ANG_W'(qd) * ANG_W'(DEG90);
      remhi       = h1_ff - qmul;
      ent_in.quad = qd[1:0];
      ent_in.rem  = {remhi[6:0], alo1_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vec0_ff  <= vec_in;
         mag0_ff  <= mag_in;
         neg0_ff  <= neg_in;
         zero0_ff <= (axis_in == '0);
         h0_ff    <= h_in;
         alo0_ff  <= req_data.angle_deg[FRAC_BITS-1:0];
         vec1_ff  <= vec0_ff;
         mag1_ff  <= mag0_ff;
         neg1_ff  <= neg0_ff;
         zero1_ff <= zero0_ff;
         h1_ff    <= h0_ff;
         alo1_ff  <= alo0_ff;
         bl1_ff   <= bl_in;
         prod1_ff <= PROD_W'(h0_ff) * PROD_W'(RECIP90);
         ent_ff   <= ent_in;
      end
   end

endmodule

@@ design/aavr_queue.sv @@
`timescale 1ns / 1ps
// Short queue of classified items between front and back ends.
// Uses aavr_pkg for the entry and status types.
module aavr_queue import aavr_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  qent_type  push_ent,
   input  logic      pop,
   output qent_type  head,
   output qstat_type qstat
);

   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   qent_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, rd_ff;
   logic [CNTW-1:0] cnt_ff, cnt_in;

   assign head        = mem_ff[rd_ff];
   assign qstat.full  = (cnt_ff == CNTW'(DEPTH));
   assign qstat.empty = (cnt_ff == '0);

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_ent;
      end
   end

endmodule

@@ design/aavr_back.sv @@
`timescale 1ns / 1ps
// Back end: square root, axis division, CORDIC, rotation matrix and product,
// one item per stage. Uses aavr_pkg.
module aavr_back import aavr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  qent_type  head,
   input  qstat_type qstat,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   localparam int LAT   = 72;
   localparam int S_CS  = 32;
   localparam int SQ_W  = 62;
   localparam int CD_W  = 33;
   localparam int DR_W  = 61;
   localparam int N_W   = 31;

   typedef struct packed {
      logic [2:0][COMP_W-1:0] vec;
      logic [2:0][NORM_W-1:0] mag;
      logic [2:0]             neg;
      logic                   zero;
      logic [1:0]             quad;
      logic [COMP_W-1:0]      cosv;
      logic [COMP_W-1:0]      sinv;
   } side_type;

   function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = v + 64'sd536870912;
      return t[63:30];
   endfunction

   logic             adv;
   logic [LAT-1:0]   vld_ff;
   side_type         side_ff [LAT-1];
   side_type         side_in;
   side_type         side_cs;

   logic [59:0]      sq_ff [3];
   logic [47:0]      zp_ff;
   logic [SQ_W-1:0]  sum_ff;
   logic [47:0]      zr;
   logic [31:0]      z1_ff;

   logic [SQ_W-1:0]  sx_ff [SQRT_STEPS];
   logic [SQ_W-1:0]  sr_ff [SQRT_STEPS];

   logic signed [CD_W-1:0] cx_ff [CORDIC_STEPS];
   logic signed [CD_W-1:0] cy_ff [CORDIC_STEPS];
   logic signed [CD_W-1:0] cz_ff [CORDIC_STEPS];
   logic signed [COMP_W-1:0] cc, ss, cos_in, sin_in;

   logic [DR_W-1:0]  dr_ff [DIV_STEPS][3];
   logic [N_W-1:0]   dq_ff [DIV_STEPS][3];
   logic [N_W-1:0]   dn_ff [DIV_STEPS];

   logic signed [COMP_W-1:0] k_ff [3];
   logic signed [63:0]       psk_ff [3];
   logic signed [63:0]       pkk_ff [6];
   logic signed [CD_W-1:0]   t_ff, t2_ff;
   logic signed [COMP_W-1:0] sk_ff [3];
   logic signed [COMP_W-1:0] sk2_ff [3];
   logic signed [COMP_W-1:0] kk_ff [6];
   logic signed [63:0]       pt_ff [6];
   logic signed [COMP_W-1:0] e_ff [3][3];
   logic signed [63:0]       pe_ff [3][3];
   logic signed [63:0]       acc_ff [3];
   rsp_type                  out_ff, out_in;

   assign adv       = !(vld_ff[LAT-1] && !rsp_ready);
   assign pop       = !qstat.empty && adv;
   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], pop};
      end
   end

   always_comb begin
      side_in.vec  = head.vec;
      side_in.mag  = head.mag;
      side_in.neg  = head.neg;
      side_in.zero = head.zero;
      side_in.quad = head.quad;
      side_in.cosv = '0;
      side_in.sinv = '0;
   end

   always_comb begin
      if (cx_ff[CORDIC_STEPS-1] < 0) begin
         cc = '0;
      end else if (cx_ff[CORDIC_STEPS-1] > (CD_W'(1) <<< 30)) begin
         cc = COMP_W'(1) <<< 30;
      end else begin
         cc = COMP_W'(cx_ff[CORDIC_STEPS-1]);
      end
      if (cy_ff[CORDIC_STEPS-1] < 0) begin
         ss = '0;
      end else if (cy_ff[CORDIC_STEPS-1] > (CD_W'(1) <<< 30)) begin
         ss = COMP_W'(1) <<< 30;
      end else begin
         ss = COMP_W'(cy_ff[CORDIC_STEPS-1]);
      end
      case (side_ff[S_CS-1].quad)
         2'd0:    begin cos_in = cc;  sin_in = ss;  end
         2'd1:    begin cos_in = -ss; sin_in = cc;  end
         2'd2:    begin cos_in = -cc; sin_in = -ss; end
         default: begin cos_in = ss;  sin_in = -cc; end
      endcase
   end

   always_comb begin
      side_cs      = side_ff[S_CS-1];
      side_cs.cosv = cos_in;
      side_cs.sinv = sin_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < LAT - 1; s++) begin
            side_ff[s] <= (s == S_CS) ? side_cs : side_ff[s-1];
         end
      end
   end

   assign zr = zp_ff + 48'd32768;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= 60'(head.mag[i]) * 60'(head.mag[i]);
         end
         zp_ff  <= 48'(head.rem) * 48'(D2R30);
         sum_ff <= SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);
         z1_ff  <= zr[47:16];
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [SQ_W-1:0] x_i, r_i, trial;
      if (k == 0) begin : g_first
         assign x_i = sum_ff;
         assign r_i = '0;
      end else begin : g_next
         assign x_i = sx_ff[k-1];
         assign r_i = sr_ff[k-1];
      end
      assign trial = r_i + BIT;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (x_i >= trial) begin
               sx_ff[k] <= x_i - trial;
               sr_ff[k] <= (r_i >> 1) + BIT;
            end else begin
               sx_ff[k] <= x_i;
               sr_ff[k] <= r_i >> 1;
            end
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam logic signed [CD_W-1:0] ANG = CD_W'(ATAN_Q30[i]);
      logic signed [CD_W-1:0] x_i, y_i, z_i, xs, ys;
      if (i == 0) begin : g_first
         assign x_i = CD_W'(CORDIC_K30);
         assign y_i = '0;
         assign z_i = $signed({1'b0, z1_ff});
      end else begin : g_next
         assign x_i = cx_ff[i-1];
         assign y_i = cy_ff[i-1];
         assign z_i = cz_ff[i-1];
      end
      assign xs = x_i >>> i;
      assign ys = y_i >>> i;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!z_i[CD_W-1]) begin
               cx_ff[i] <= x_i - ys;
               cy_ff[i] <= y_i + xs;
               cz_ff[i] <= z_i - ANG;
            end else begin
               cx_ff[i] <= x_i + ys;
               cy_ff[i] <= y_i - xs;
               cz_ff[i] <= z_i + ANG;
            end
         end
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [N_W-1:0] n_i;
      if (k == 0) begin : g_first
         assign n_i = sr_ff[SQRT_STEPS-1][N_W-1:0];
      end else begin : g_next
         assign n_i = dn_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dn_ff[k] <= n_i;
         end
      end
      for (genvar c = 0; c < 3; c++) begin : g_comp
         logic [DR_W-1:0] r_i;
         logic [N_W-1:0]  q_i;
         logic [DR_W:0]   dsh;
         if (k == 0) begin : g_first
            assign r_i = {1'b0, side_ff[S_CS].mag[c], 30'b0} + DR_W'(n_i >> 1);
            assign q_i = '0;
         end else begin : g_next
            assign r_i = dr_ff[k-1][c];
            assign q_i = dq_ff[k-1][c];
         end
         assign dsh = (DR_W+1)'(n_i) << (DIV_STEPS - 1 - k);
         always_ff @(posedge clock) begin
            if (adv) begin
               if ({1'b0, r_i} >= dsh) begin
                  dr_ff[k][c] <= r_i - DR_W'(dsh);
                  dq_ff[k][c] <= {q_i[N_W-2:0], 1'b1};
               end else begin
                  dr_ff[k][c] <= r_i;
                  dq_ff[k][c] <= {q_i[N_W-2:0], 1'b0};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            k_ff[i] <= side_ff[S_CS+DIV_STEPS].neg[i]
                       ? -$signed({1'b0, dq_ff[DIV_STEPS-1][i]})
                       : $signed({1'b0, dq_ff[DIV_STEPS-1][i]});
            psk_ff[i] <= $signed(side_ff[64].sinv) * k_ff[i];
            sk_ff[i]  <= COMP_W'(rnd30(psk_ff[i]));
            sk2_ff[i] <= sk_ff[i];
         end
         pkk_ff[0] <= k_ff[0] * k_ff[0];
         pkk_ff[1] <= k_ff[1] * k_ff[1];
         pkk_ff[2] <= k_ff[2] * k_ff[2];
         pkk_ff[3] <= k_ff[0] * k_ff[1];
         pkk_ff[4] <= k_ff[0] * k_ff[2];
         pkk_ff[5] <= k_ff[1] * k_ff[2];
         t_ff  <= (CD_W'(1) <<< 30) - CD_W'($signed(side_ff[64].cosv));
         t2_ff <= t_ff;
         for (int m = 0; m < 6; m++) begin
            kk_ff[m] <= COMP_W'(rnd30(pkk_ff[m]));
            pt_ff[m] <= t2_ff * kk_ff[m];
         end
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int KI = (i == j) ? i : (i + j + 2);
         localparam int SI = (i == j) ? 0 : (3 - i - j);
         localparam bit SPOS = (((j - i + 3) % 3) == 2);
         logic signed [33:0] diag, skt, ent;
         assign diag = (i == j) ? 34'($signed(side_ff[67].cosv)) : '0;
         assign skt  = (i == j) ? '0 : (SPOS ? 34'(sk2_ff[SI]) : -34'(sk2_ff[SI]));
         assign ent  = diag + rnd30(pt_ff[KI]) + skt;
         always_ff @(posedge clock) begin
            if (adv) begin
               if (ent > (34'sd1 <<< 30)) begin
                  e_ff[i][j] <= COMP_W'(1) <<< 30;
               end else if (ent < -(34'sd1 <<< 30)) begin
                  e_ff[i][j] <= -(COMP_W'(1) <<< 30);
               end else begin
                  e_ff[i][j] <= COMP_W'(ent);
               end
               pe_ff[i][j] <= e_ff[i][j] * $signed(side_ff[68].vec[j]);
            end
         end
      end
   end

   always_comb begin
      logic signed [63:0] t;
      logic signed [33:0] res;
      comp_type           rot [3];
      logic               ovf;
      ovf = 1'b0;
      for (int i = 0; i < 3; i++) begin
         t   = acc_ff[i] + 64'sd536870912;
         res = t[63:30];
         if (res > 34'(COMP_MAX)) begin
            rot[i] = COMP_MAX;
            ovf    = 1'b1;
         end else if (res < 34'(COMP_MIN)) begin
            rot[i] = COMP_MIN;
            ovf    = 1'b1;
         end else begin
            rot[i] = COMP_W'(res);
         end
      end
      if (side_ff[LAT-2].zero) begin
         out_in.rot_x     = '0;
         out_in.rot_y     = '0;
         out_in.rot_z     = '0;
         out_in.axis_zero = 1'b1;
         out_in.overflow  = 1'b0;
      end else begin
         out_in.rot_x     = rot[0];
         out_in.rot_y     = rot[1];
         out_in.rot_z     = rot[2];
         out_in.axis_zero = 1'b0;
         out_in.overflow  = ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= pe_ff[i][0] + pe_ff[i][1] + pe_ff[i][2];
         end
         out_ff <= out_in;
      end
   end

endmodule

@@ design/axis_angle_vector_rotation.sv @@
`timescale 1ns / 1ps
// Axis-angle vector rotation top level (Rodrigues' formula, Q16.16).
// Depends on aavr_pkg, aavr_front, aavr_queue and aavr_back.
//
// Fully pipelined: one beat per cycle sustained while rsp_ready stays high;
// a request passes 3 front stages, one queue slot and 72 back stages.
// Latency is set by the 31-stage square root, the 31-stage axis divider and
// the 30-stage CORDIC that runs beside the root. The queue and the front
// stages let the front end keep taking beats for QUEUE_DEPTH + 3 items while
// the response side stalls.
// A zero axis returns a zero vector with axis_zero set.
module axis_angle_vector_rotation import aavr_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic      q_push, q_pop;
   qent_type  q_in, q_head;
   qstat_type q_stat;

   aavr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .qstat     (q_stat),
      .push      (q_push),
      .push_ent  (q_in)
   );

   aavr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_ent (q_in),
      .pop      (q_pop),
      .head     (q_head),
      .qstat    (q_stat)
   );

   aavr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .qstat     (q_stat),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_zero_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.axis_zero |->
         rsp_data.rot_x == '0 && rsp_data.rot_y == '0 && rsp_data.rot_z == '0 &&
         !rsp_data.overflow)
      else $error("zero axis beat carries nonzero data");

   a_ovf_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |->
         rsp_data.rot_x == COMP_MAX || rsp_data.rot_x == COMP_MIN ||
         rsp_data.rot_y == COMP_MAX || rsp_data.rot_y == COMP_MIN ||
         rsp_data.rot_z == COMP_MAX || rsp_data.rot_z == COMP_MIN)
      else $error("overflow flagged without a saturated component");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !q_push)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_stat.empty |-> !q_pop)
      else $error("pop from empty queue");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for axis_angle_vector_rotation: directed table, then random beats.
// Depends on aavr_pkg and the block's RTL; predicts each rotation bit for bit.
module tb;
   import aavr_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   axis_angle_vector_rotation uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   localparam longint ONE_Q30  = 64'sd1 << 30;
   localparam longint HALF_Q30 = 64'sd1 << 29;
   localparam int     STALL_LEN = 300;
   localparam int     CYCLE_LIMIT = 1000000;

   rsp_type rotations_due[$];
   int      errors = 0;
   int      beats_sent = 0;
   int      beats_seen = 0;
   int      zero_axes = 0;
   int      saturations = 0;
   int      cycle_count = 0;
   bit      hold_off = 1'b0;
   bit      stim_done = 1'b0;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_q30(longint v);
      return floor_shift(v + HALF_Q30, 30);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint root_floor(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic rsp_type rotate_vector(req_type rq);
      rsp_type res;
      longint v[3], ax[3], k[3], sk[3], rm[3][3];
      longint unsigned mag[3], mx, sum, n, kv;
      longint full_turn, quarter, ang, rem, x, y, z, xs, ys, cc, ss, c, s, t;
      longint vh[3], vl[3], hi, lo, hq, hr, acc, e, lo_lim, hi_lim;
      int bl, q;
      bit ovf;
      res = '0;
      ovf = 1'b0;
      v[0] = rq.vec_x; v[1] = rq.vec_y; v[2] = rq.vec_z;
      ax[0] = rq.axis_x; ax[1] = rq.axis_y; ax[2] = rq.axis_z;
      if (ax[0] == 0 && ax[1] == 0 && ax[2] == 0) begin
         res.axis_zero = 1'b1;
         return res;
      end
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = ax[i] < 0 ? -ax[i] : ax[i];
         if (mag[i] > mx) mx = mag[i];
      end
      bl = 0;
      while (mx != 0) begin
         bl++;
         mx >>= 1;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         if (bl > 30) mag[i] >>= (bl - 30);
         else mag[i] <<= (30 - bl);
         sum += mag[i] * mag[i];
      end
      n = root_floor(sum);
      if (n == 0) n = 1;
      for (int i = 0; i < 3; i++) begin
         kv = (mag[i] * ONE_Q30 + n / 2) / n;
         k[i] = ax[i] < 0 ? -longint'(kv) : longint'(kv);
      end
      full_turn = 64'sd360 <<< FRAC_BITS;
      quarter = 64'sd90 <<< FRAC_BITS;
      ang = longint'(rq.angle_deg) % full_turn;
      if (ang < 0) ang += full_turn;
      q = int'(ang / quarter) & 3;
      rem = ang - q * quarter;
      z = (rem * 64'sd18740330 + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
         end else begin
            x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
         end
      end
      cc = clip(x, 0, ONE_Q30);
      ss = clip(y, 0, ONE_Q30);
      case (q)
         0: begin c = cc; s = ss; end
         1: begin c = -ss; s = cc; end
         2: begin c = -cc; s = -ss; end
         default: begin c = ss; s = -cc; end
      endcase
      t = ONE_Q30 - c;
      for (int i = 0; i < 3; i++) sk[i] = round_q30(s * k[i]);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            rm[i][j] = (i == j ? c : 0) + round_q30(t * round_q30(k[i] * k[j]));
      rm[0][1] -= sk[2]; rm[0][2] += sk[1];
      rm[1][0] += sk[2]; rm[1][2] -= sk[0];
      rm[2][0] -= sk[1]; rm[2][1] += sk[0];
      lo_lim = longint'(COMP_MIN);
      hi_lim = longint'(COMP_MAX);
      for (int j = 0; j < 3; j++) begin
         vh[j] = floor_shift(v[j], 16);
         vl[j] = v[j] - vh[j] * 65536;
      end
      for (int i = 0; i < 3; i++) begin
         hi = 0;
         lo = 0;
         for (int j = 0; j < 3; j++) begin
            e = clip(rm[i][j], -ONE_Q30, ONE_Q30);
            hi += e * vh[j];
            lo += e * vl[j];
         end
         hq = floor_shift(hi, 14);
         hr = hi - hq * 16384;
         acc = hq + floor_shift(hr * 65536 + lo + HALF_Q30, 30);
         if (acc < lo_lim) begin acc = lo_lim; ovf = 1'b1; end
         if (acc > hi_lim) begin acc = hi_lim; ovf = 1'b1; end
         case (i)
            0: res.rot_x = comp_type'(acc);
            1: res.rot_y = comp_type'(acc);
            default: res.rot_z = comp_type'(acc);
         endcase
      end
      res.overflow = ovf;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch beat %0d %s: got %0d, want %0d", beats_seen, what, got, want);
   endtask

   // directed rows: typed result only where obvious, else predictor
   typedef struct {
      req_type rq;
      bit      typed;
      rsp_type want;
   } row_type;

   function automatic req_type mk(longint vx, longint vy, longint vz,
                                  longint kx, longint ky, longint kz, longint a);
      req_type r;
      r.vec_x = comp_type'(vx); r.vec_y = comp_type'(vy); r.vec_z = comp_type'(vz);
      r.axis_x = comp_type'(kx); r.axis_y = comp_type'(ky); r.axis_z = comp_type'(kz);
      r.angle_deg = comp_type'(a);
      return r;
   endfunction

   function automatic comp_type rnd_comp();
      case ($urandom_range(0, 5))
         0: return COMP_MAX;
         1: return COMP_MIN;
         2: return comp_type'($urandom_range(0, 1 << 20)) - (1 << 19);
         3: return comp_type'($urandom_range(0, 1 << 24)) - (1 << 23);
         default: return comp_type'($urandom);
      endcase
   endfunction

   function automatic req_type rnd_req();
      req_type r;
      r.vec_x = rnd_comp(); r.vec_y = rnd_comp(); r.vec_z = rnd_comp();
      r.axis_x = rnd_comp(); r.axis_y = rnd_comp(); r.axis_z = rnd_comp();
      case ($urandom_range(0, 9))
         0: r.axis_x = 0;
         1: begin r.axis_y = 0; r.axis_z = 0; end
         2: begin r.axis_x = 0; r.axis_y = 0; r.axis_z = 0; end
         3: r.axis_z = $urandom_range(0, 1) ? 1 : -1;
         default: ;
      endcase
      case ($urandom_range(0, 3))
         0: r.angle_deg = ($urandom_range(0, 8) * 90 - 360) <<< FRAC_BITS;
         1: r.angle_deg = comp_type'($urandom_range(0, 720 << 16)) - (360 << 16);
         default: r.angle_deg = $urandom;
      endcase
      return r;
   endfunction

   row_type rows[$];

   task automatic send_beat(req_type rq, bit typed, rsp_type want);
      req_valid <= 1'b1;
      req_data <= rq;
      rotations_due.push_back(typed ? want : rotate_vector(rq));
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
   endtask

   initial begin
      rsp_type zr, same;
      int burst;
      zr = '0;
      zr.axis_zero = 1'b1;
      rows.push_back('{mk(1 << 16, 2 << 16, 3 << 16, 0, 0, 0, 45 << 16), 1'b1, zr});
      rows.push_back('{mk(COMP_MAX, COMP_MIN, COMP_MAX, 0, 0, 0, COMP_MIN), 1'b1, zr});
      same = '0;
      same.rot_x = 5 << 16; same.rot_y = -(7 << 16); same.rot_z = 3 << 16;
      rows.push_back('{mk(5 << 16, -(7 << 16), 3 << 16, 0, 0, 1 << 16, 0), 1'b1, same});
      rows.push_back('{mk(0, 0, 0, 1, 2, 3, 77 << 16), 1'b1, '0});
      rows.push_back('{mk(1 << 16, 0, 0, 0, 0, 1 << 16, 90 << 16), 1'b0, '0});
      rows.push_back('{mk(1 << 16, 0, 0, 0, 0, 1 << 16, 180 << 16), 1'b0, '0});
      rows.push_back('{mk(1 << 16, 0, 0, 0, 0, 1 << 16, 270 << 16), 1'b0, '0});
      rows.push_back('{mk(1 << 16, 0, 0, 0, 0, 1 << 16, -(90 << 16)), 1'b0, '0});
      rows.push_back('{mk(0, 1 << 16, 0, 1 << 16, 0, 0, 360 << 16), 1'b0, '0});
      rows.push_back('{mk(COMP_MAX, COMP_MAX, COMP_MAX, 1, 1, 1, 60 << 16), 1'b0, '0});
      rows.push_back('{mk(COMP_MIN, COMP_MIN, COMP_MIN, -1, 1, -1, 45 << 16), 1'b0, '0});
      rows.push_back('{mk(COMP_MAX, COMP_MIN, 0, COMP_MIN, COMP_MIN, COMP_MIN, 30 << 16),
                       1'b0, '0});
      rows.push_back('{mk(-1, 1, -1, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX), 1'b0, '0});
      rows.push_back('{mk(1 << 20, 3 << 16, -1, 0, COMP_MAX, 1, COMP_MIN), 1'b0, '0});
      rows.push_back('{mk(12345, -6789, 1 << 30, 7, -3, 0, 1), 1'b0, '0});
      rows.push_back('{mk(COMP_MAX, 0, 0, 0, 1 << 16, 0, 45 << 16), 1'b0, '0});
      rows.push_back('{mk(1 << 16, 1 << 16, 1 << 16, 1 << 16, 1 << 16, 0, -(1 << 16)),
                       1'b0, '0});
      rows.push_back('{mk(-(2 << 16), 5, 9, COMP_MIN, 0, 0, 89 << 16), 1'b0, '0});

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_beat(rows[i].rq, rows[i].typed, rows[i].want);
      drop_valid();

      // long receiver hold-off while the sender keeps offering
      hold_off = 1'b1;
      repeat (120) send_beat(rnd_req(), 1'b0, '0);
      drop_valid();
      wait (!hold_off);
      wait (rotations_due.size() == 0);
      @(negedge clock);

      while (beats_sent < 1400) begin
         burst = $urandom_range(1, 30);
         repeat (burst) send_beat(rnd_req(), 1'b0, '0);
         if ($urandom_range(0, 1)) begin
            drop_valid();
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         if (beats_sent > 700 && beats_sent < 731) begin
            drop_valid();
            wait (rotations_due.size() == 0);
            @(negedge clock);
         end
      end
      drop_valid();
      stim_done = 1'b1;
   end

   // receiver: own stall pattern, plus one long hold-off
   initial begin
      int phase;
      phase = 0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (STALL_LEN) @(negedge clock);
            hold_off = 1'b0;
         end
         phase++;
         if ((phase / 200) % 3 == 0) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0) || phase[4];
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_seen++;
         if (rotations_due.size() == 0) begin
            errors++;
            $display("unexpected response beat %0d", beats_seen);
         end else begin
            want = rotations_due.pop_front();
            if (rsp_data.rot_x !== want.rot_x) report_mismatch("rot_x", rsp_data.rot_x, want.rot_x);
            if (rsp_data.rot_y !== want.rot_y) report_mismatch("rot_y", rsp_data.rot_y, want.rot_y);
            if (rsp_data.rot_z !== want.rot_z) report_mismatch("rot_z", rsp_data.rot_z, want.rot_z);
            if (rsp_data.axis_zero !== want.axis_zero)
               report_mismatch("axis_zero", rsp_data.axis_zero, want.axis_zero);
            if (rsp_data.overflow !== want.overflow)
               report_mismatch("overflow", rsp_data.overflow, want.overflow);
            if (want.axis_zero) zero_axes++;
            if (want.overflow) saturations++;
         end
      end
   end

   initial begin
      wait (stim_done);
      wait (rotations_due.size() == 0);
      repeat (200) @(posedge clock);
      $display("sent %0d beats, got %0d; %0d zero-axis, %0d saturated",
               beats_sent, beats_seen, zero_axes, saturations);
      if (errors == 0 && rotations_due.size() == 0) begin
         $display("[axis_angle_vector_rotation] OK");
      end else begin
         $display("%0d errors", errors);
         $display("[axis_angle_vector_rotation] ERROR");
      end
      $finish;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", rotations_due.size());
         $display("[axis_angle_vector_rotation] ERROR");
         $finish;
      end
   end

endmodule
